// ===== hdl/aspsel_pkg.sv =====
// aspsel_pkg: shared widths, codes, record types and helper functions for the
// alignment site pair selector; no dependencies
`timescale 1ns / 1ps

package aspsel_pkg;

    localparam int CNT_W  = 10;
    localparam int SUM_W  = 24;
    localparam int STAT_W = 16;
    localparam int SITE_W = 32;
    localparam int CFG_W  = 10;
    localparam int NBASE  = 4;
    localparam int NCLASS = 5;
    localparam int CUBE_W = 14;

    localparam int MAX_SEQUENCES   = 1023;
    localparam int SITE_INDEX_BITS = 32;
    localparam int DIST_MIN_SEQ    = 20;
    localparam int DROP_SCALE      = 216000;   // 60 cubed

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};
    localparam logic [CFG_W-1:0]  DIST_RESET = 10'd20;

    // objective mode codes
    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_RY   = 2'd1;
    localparam logic [1:0] MODE_FULL = 2'd2;
    localparam logic [1:0] MODE_AUTO = 2'd3;

    // column classes
    localparam logic [2:0] CLS_EMPTY    = 3'd0;
    localparam logic [2:0] CLS_ONE      = 3'd1;
    localparam logic [2:0] CLS_TWO      = 3'd2;
    localparam logic [2:0] CLS_FOUR_VAR = 3'd5;

    typedef enum logic [1:0] {
        CFG_OBJECTIVE = 2'd0,
        CFG_NUM_SEQ   = 2'd1,
        CFG_PAIR_DIST = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic       single;
        logic [2:0] cls;
    } kind_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CFG_W-1:0] nseq;
        logic [CFG_W-1:0] pair_gap;
    } cfg_t;

    typedef struct packed {
        logic [NBASE-1:0][CNT_W-1:0] cnt;
        logic [SITE_W-1:0]           site;
        logic                        first;
        logic                        last;
    } column_t;

    typedef struct packed {
        logic                        pair_valid;
        logic [SITE_W-1:0]           first_site;
        logic [SITE_W-1:0]           second_site;
        logic                        full;
        logic                        sum_valid;
        logic [NBASE-1:0][SUM_W-1:0] sums;
        logic                        drop_force;
        logic                        drop_test;
        logic signed [CUBE_W-1:0]    cube;
        logic [STAT_W-1:0]           four_cnt;
        logic [STAT_W-1:0]           var_cnt;
    } rec_t;

    // class one never pairs with a singleton or with another class one
    function automatic logic pair_allowed(input kind_t cur, input kind_t prev);
        logic ok;
        ok = 1'b1;
        if (cur.cls == CLS_ONE && prev.single)
            ok = 1'b0;
        if (prev.cls == CLS_ONE && cur.single)
            ok = 1'b0;
        if (cur.cls == CLS_ONE && prev.cls == CLS_ONE)
            ok = 1'b0;
        return ok;
    endfunction

    // (n - 1) cubed for the small sequence counts that use the drop test
    function automatic logic signed [CUBE_W-1:0] cube_of(input logic [4:0] n);
        logic signed [CUBE_W-1:0] v;
        case (n)
            5'd0:    v = -14'sd1;
            5'd1:    v = 14'sd0;
            5'd2:    v = 14'sd1;
            5'd3:    v = 14'sd8;
            5'd4:    v = 14'sd27;
            5'd5:    v = 14'sd64;
            5'd6:    v = 14'sd125;
            5'd7:    v = 14'sd216;
            5'd8:    v = 14'sd343;
            5'd9:    v = 14'sd512;
            5'd10:   v = 14'sd729;
            5'd11:   v = 14'sd1000;
            5'd12:   v = 14'sd1331;
            5'd13:   v = 14'sd1728;
            5'd14:   v = 14'sd2197;
            5'd15:   v = 14'sd2744;
            5'd16:   v = 14'sd3375;
            5'd17:   v = 14'sd4096;
            5'd18:   v = 14'sd4913;
            5'd19:   v = 14'sd5832;
            default: v = 14'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/aspsel_track.sv =====
// aspsel_track: column classification, per-class and neighbour pairing state
// and chunk statistics; depends on aspsel_pkg
`timescale 1ns / 1ps

module aspsel_track #(
    parameter int SITE_INDEX_BITS = aspsel_pkg::SITE_INDEX_BITS,
    parameter int MAX_SEQUENCES   = aspsel_pkg::MAX_SEQUENCES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  aspsel_pkg::column_t col,
    input  aspsel_pkg::cfg_t    cfg,
    output aspsel_pkg::rec_t    rec
);
    import aspsel_pkg::*;

    localparam int SW = (SITE_INDEX_BITS < SITE_W) ? SITE_INDEX_BITS : SITE_W;

    logic [SW-1:0]               pos_reg   [NCLASS];
    kind_t                       kind_reg  [NCLASS];
    logic [NCLASS-1:0]           valid_reg;
    kind_t                       prev_kind_reg;
    logic                        prev_valid_reg;
    logic [STAT_W-1:0]           four_reg;
    logic [STAT_W-1:0]           var_reg;
    logic [NBASE-1:0][SUM_W-1:0] sums_reg;

    logic [SW-1:0]               pos_next  [NCLASS];
    kind_t                       kind_next [NCLASS];
    logic [NCLASS-1:0]           valid_next;
    kind_t                       prev_kind_next;
    logic                        prev_valid_next;
    logic [STAT_W-1:0]           four_next;
    logic [STAT_W-1:0]           var_next;
    logic [NBASE-1:0][SUM_W-1:0] sums_next;

    logic [NCLASS-1:0]           valid_eff;
    logic                        prev_valid_eff;
    logic [STAT_W-1:0]           four_eff;
    logic [STAT_W-1:0]           var_eff;
    logic [NBASE-1:0][SUM_W-1:0] sums_eff;
    logic [SUM_W:0]              sum_wide;
    logic [2:0]                  nz;
    logic                        has_one;
    kind_t                       kind;
    logic [2:0]                  slot;
    logic [SW-1:0]               j;
    logic [SW:0]                 reach;
    logic                        dist_mode;
    logic [CFG_W-1:0]            n_eff;
    kind_t                       pk;

    always_comb
    begin
        n_eff = (32'(cfg.nseq) > MAX_SEQUENCES) ? CFG_W'(MAX_SEQUENCES) : cfg.nseq;
        j     = col.site[SW-1:0];

        // chunk start clears the chunk before this column
        valid_eff      = col.first ? '0 : valid_reg;
        prev_valid_eff = col.first ? 1'b0 : prev_valid_reg;
        four_eff       = col.first ? '0 : four_reg;
        var_eff        = col.first ? '0 : var_reg;
        sums_eff       = col.first ? '0 : sums_reg;

        nz      = '0;
        has_one = 1'b0;
        for (int k = 0; k < NBASE; k++)
        begin
            if (col.cnt[k] != '0)
                nz = nz + 3'd1;
            if (col.cnt[k] == CNT_W'(1))
                has_one = 1'b1;
            sum_wide     = {1'b0, sums_eff[k]} + (SUM_W+1)'(col.cnt[k]);
            sums_next[k] = (sum_wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
        end

        four_next = four_eff;
        if (nz == 3'd4 && four_eff != STAT_MAX)
            four_next = four_eff + STAT_W'(1);
        var_next = var_eff;
        if (nz != 3'd0 && var_eff != STAT_MAX)
            var_next = var_eff + STAT_W'(1);

        // four bases never leave a singleton, so class four becomes class five
        kind.single = has_one && (nz <= 3'd2);
        kind.cls    = (nz == 3'd4) ? CLS_FOUR_VAR : nz;

        dist_mode = (cfg.mode == MODE_AUTO) && (n_eff >= CFG_W'(DIST_MIN_SEQ))
                    && (cfg.pair_gap != '0);
        slot      = (kind.cls == CLS_EMPTY) ? 3'd0 : kind.cls - 3'd1;
        reach     = (SW+1)'(pos_reg[slot]) + (SW+1)'(cfg.pair_gap);
        pk        = dist_mode ? kind_reg[slot] : prev_kind_reg;

        for (int k = 0; k < NCLASS; k++)
        begin
            pos_next[k]  = pos_reg[k];
            kind_next[k] = kind_reg[k];
        end
        valid_next      = valid_eff;
        prev_kind_next  = kind;
        prev_valid_next = 1'b1;

        rec = '0;
        if (kind.cls != CLS_EMPTY)
        begin
            if (dist_mode)
            begin
                if (valid_eff[slot] && reach >= {1'b0, j} && pair_allowed(kind, pk))
                begin
                    rec.pair_valid  = 1'b1;
                    rec.first_site  = SITE_W'(pos_reg[slot]);
                    rec.second_site = SITE_W'(j);
                    rec.full        = (kind.cls != CLS_FOUR_VAR) && (pk.cls < CLS_FOUR_VAR);
                end
                if (kind.cls > CLS_TWO)
                begin
                    pos_next[slot]   = j;
                    kind_next[slot]  = kind;
                    valid_next[slot] = 1'b1;
                end
                else
                begin
                    // classes one and two share slots 0 and 1
                    for (int k = 0; k < 2; k++)
                    begin
                        pos_next[k]   = j;
                        kind_next[k]  = kind;
                        valid_next[k] = 1'b1;
                    end
                end
            end
            else if (prev_valid_eff && pair_allowed(kind, pk))
            begin
                rec.pair_valid  = 1'b1;
                rec.first_site  = SITE_W'(j - SW'(1));
                rec.second_site = SITE_W'(j);
                rec.full        = 1'b1;
            end
        end

        if (col.last)
        begin
            rec.sum_valid  = 1'b1;
            rec.sums       = sums_next;
            rec.drop_force = (cfg.mode == MODE_RY);
            rec.drop_test  = (cfg.mode == MODE_AUTO) && (n_eff < CFG_W'(DIST_MIN_SEQ));
            rec.cube       = cube_of(n_eff[4:0]);
            rec.four_cnt   = four_next;
            rec.var_cnt    = var_next;
            // chunk end clears after the summary
            valid_next      = '0;
            prev_valid_next = 1'b0;
            four_next       = '0;
            var_next        = '0;
            sums_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            prev_valid_reg <= 1'b0;
            four_reg       <= '0;
            var_reg        <= '0;
            sums_reg       <= '0;
        end
        else if (accept)
        begin
            valid_reg      <= valid_next;
            prev_valid_reg <= prev_valid_next;
            four_reg       <= four_next;
            var_reg        <= var_next;
            sums_reg       <= sums_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_kind_reg <= prev_kind_next;
            for (int k = 0; k < NCLASS; k++)
            begin
                pos_reg[k]  <= pos_next[k];
                kind_reg[k] <= kind_next[k];
            end
        end
    end

endmodule

// ===== hdl/aspsel_out.sv =====
// aspsel_out: two-entry result queue, drop test and output beat formatting
// depends on aspsel_pkg
`timescale 1ns / 1ps

module aspsel_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  aspsel_pkg::rec_t rec,
    output logic             space,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [167:0]     m_data,
    output logic             m_user,
    output logic             m_last
);
    import aspsel_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam int LHS_W = STAT_W + 18;
    localparam int RHS_W = STAT_W + 1 + CUBE_W;
    localparam int CMP_W = LHS_W + 2;

    rec_t              q_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;
    logic              phase_reg;

    rec_t                    head;
    logic                    pair_sel;
    logic                    take;
    logic                    pop;
    logic [LHS_W-1:0]        lhs;
    logic signed [RHS_W-1:0] rhs;
    logic                    drop;

    assign head     = q_reg[rd_ptr_reg];
    assign m_valid  = (count_reg != '0);
    assign space    = (count_reg != CNT_QW'(DEPTH));
    assign pair_sel = head.pair_valid && !phase_reg;
    assign take     = m_valid && m_ready;
    assign pop      = take && !(pair_sel && head.sum_valid);

    always_comb
    begin
        lhs  = LHS_W'(head.four_cnt) * LHS_W'(DROP_SCALE);
        rhs  = $signed({1'b0, head.var_cnt}) * head.cube;
        drop = head.drop_force ||
               (head.drop_test && ($signed({2'b00, lhs}) > CMP_W'(rhs)));

        m_data = '0;
        m_user = !pair_sel;
        m_last = !pair_sel || !head.sum_valid;
        if (pair_sel)
        begin
            m_data[31:0]  = head.first_site;
            m_data[63:32] = head.second_site;
            m_data[64]    = head.full;
        end
        else
        begin
            m_data[65]      = drop;
            m_data[89:66]   = head.sums[0];
            m_data[113:90]  = head.sums[1];
            m_data[137:114] = head.sums[2];
            m_data[161:138] = head.sums[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_QW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_QW'(1);
            // pair sent, summary of the same column still to go
            if (take)
                phase_reg <= !pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= rec;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_QW'(DEPTH))
        else $error("result queue over depth");
    a_phase_has_sum: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (m_valid && head.sum_valid && head.pair_valid))
        else $error("pair phase without pending summary");
    a_record_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid |-> (head.pair_valid || head.sum_valid))
        else $error("queued record holds no result");
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid && m_user) |-> m_last)
        else $error("summary beat not marked last");
`endif

endmodule

// ===== hdl/alignment_site_pair_selector_core.sv =====
// alignment_site_pair_selector_core: top level with configuration registers,
// stream ports, pairing state and result queue; depends on aspsel_pkg,
// aspsel_track and aspsel_out
`timescale 1ns / 1ps

// One alignment column is taken per clock on the slave stream while the
// two-entry result queue has space; its results (a site pair, a chunk
// summary, or both, pair first) are registered in that queue and appear on
// the master stream from it, so input keeps flowing while a result waits.
// A column that causes both a pair and a summary holds its queue entry until
// both beats are taken, which limits the sustained rate at chunk ends.
// Chunk state is held in flip-flops and needs no clearing pass after reset.
// Configuration writes must be made while the block holds no pending results.
module alignment_site_pair_selector_core #(
    parameter int SITE_INDEX_BITS = aspsel_pkg::SITE_INDEX_BITS,
    parameter int MAX_SEQUENCES   = aspsel_pkg::MAX_SEQUENCES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // count_a[9:0], count_c[19:10], count_g[29:20], count_t[39:30],
    // site_index[71:40]
    input  logic [71:0]  s_tdata,
    // chunk_first[0]
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,   // chunk_last
    output logic         m_tvalid,
    input  logic         m_tready,
    // first_site[31:0], second_site[63:32], in_full_lists[64],
    // drop_full_lists[65], sum_a[89:66], sum_c[113:90], sum_g[137:114],
    // sum_t[161:138], zero fill[167:162]
    output logic [167:0] m_tdata,
    // result_kind[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast,   // last_of_run
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [9:0]   cfg_data
);
    import aspsel_pkg::*;

    logic [1:0]       mode_reg;
    logic [CFG_W-1:0] nseq_reg;
    logic [CFG_W-1:0] dist_reg;

    cfg_t    cfg;
    column_t col;
    rec_t    rec;
    logic    accept;
    logic    push;
    logic    space;
    logic    kind_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RY;
            nseq_reg <= '0;
            dist_reg <= DIST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OBJECTIVE: mode_reg <= cfg_data[1:0];
                CFG_NUM_SEQ:   nseq_reg <= cfg_data;
                CFG_PAIR_DIST: dist_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg.mode     = mode_reg;
    assign cfg.nseq     = nseq_reg;
    assign cfg.pair_gap = dist_reg;

    assign col.cnt[0] = s_tdata[9:0];
    assign col.cnt[1] = s_tdata[19:10];
    assign col.cnt[2] = s_tdata[29:20];
    assign col.cnt[3] = s_tdata[39:30];
    assign col.site   = s_tdata[71:40];
    assign col.first  = s_tuser[0];
    assign col.last   = s_tlast;

    assign s_tready = space;
    assign accept   = s_tvalid && s_tready;
    // beats that cause no result leave the queue alone
    assign push     = accept && (rec.pair_valid || rec.sum_valid);

    aspsel_track #(
        .SITE_INDEX_BITS (SITE_INDEX_BITS),
        .MAX_SEQUENCES   (MAX_SEQUENCES)
    ) u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .col    (col),
        .cfg    (cfg),
        .rec    (rec)
    );

    aspsel_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rec     (rec),
        .space   (space),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata),
        .m_user  (kind_bit),
        .m_last  (m_tlast)
    );

    assign m_tuser[0] = kind_bit;

endmodule
